/* sv/ccc_pkg.sv */
package ccc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int NUM_REFS      = 10;
  localparam int REF_TABLE_LEN = 10;
  localparam int NUM_USED      = (NUM_REFS < REF_TABLE_LEN) ? NUM_REFS : REF_TABLE_LEN;
  localparam int NUM_PAIRS     = (NUM_USED + 1) / 2;

  localparam int CNT_W     = 16;
  localparam int SUM_W     = CNT_W + 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int NUM_W     = CNT_W + FRAC_BITS + 1;
  localparam int DIFF_W    = QUO_W;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int DIST_W    = SQ_W + 2;
  localparam int CLS_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int HEX_W     = 24;

  localparam logic [CLS_W-1:0] CLS_WHITE = CLS_W'(10);
  localparam logic [CLS_W-1:0] CLS_BLACK = CLS_W'(11);

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THR = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] WHITE_THR_RST = CNT_W'(60000);
  localparam logic [CNT_W-1:0] BLACK_THR_RST = CNT_W'(100);

  typedef enum logic [1:0] {
    SEL_NEAR,
    SEL_WHITE,
    SEL_BLACK
  } sel_e;

  // Side data that rides along with the divider pipeline
  typedef struct packed {
    logic [CNT_W-1:0] clear;
    sel_e             sel;
    logic             nz;
  } side_t;

  // Reference chromaticities in thousandths
  function automatic int ref_milli(int idx, int comp);
    int m;
    m = 0;
    case (idx)
      0: m = (comp == 0) ? 479 : (comp == 1) ? 271 : 249;
      1: m = (comp == 0) ? 506 : (comp == 1) ? 258 : 232;
      2: m = (comp == 0) ? 334 : (comp == 1) ? 333 : 331;
      3: m = (comp == 0) ? 348 : (comp == 1) ? 336 : 315;
      4: m = (comp == 0) ? 343 : (comp == 1) ? 336 : 320;
      5: m = (comp == 0) ? 343 : (comp == 1) ? 374 : 263;
      6: m = (comp == 0) ? 415 : (comp == 1) ? 360 : 225;
      7: m = (comp == 0) ? 480 : (comp == 1) ? 286 : 235;
      8: m = (comp == 0) ? 359 : (comp == 1) ? 354 : 294;
      9: m = (comp == 0) ? 443 : (comp == 1) ? 312 : 244;
      default: m = 0;
    endcase
    return m;
  endfunction

  // Reference component in fixed point, rounded half up
  function automatic logic [QUO_W-1:0] ref_fixed(int idx, int comp);
    longint v;
    v = ((longint'(ref_milli(idx, comp)) <<< FRAC_BITS) + 500) / 1000;
    return v[QUO_W-1:0];
  endfunction

endpackage

/* sv/ccc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num_i >> QUO_W is below den_i when den_i is nonzero.
module ccc_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ccc_pkg::NUM_W-1:0]   num_i,
  input  logic [ccc_pkg::SUM_W-1:0]   den_i,
  output logic [ccc_pkg::QUO_W-1:0]   quo_o
);

  localparam int QW = ccc_pkg::QUO_W;
  localparam int SW = ccc_pkg::SUM_W;

  logic [SW-1:0] rem_q [QW];
  logic [SW-1:0] rem_d [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] low_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  logic [SW-1:0] den_q [QW];
  logic [SW-1:0] den_d [QW];

  // One shift-compare-subtract step per stage
  always_comb begin
    logic [SW-1:0] prem;
    logic [QW-1:0] plow;
    logic [QW-1:0] pquo;
    logic [SW-1:0] pden;
    logic [SW:0]   t;
    logic          ge;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        prem = SW'(num_i[ccc_pkg::NUM_W-1:QW]);
        plow = num_i[QW-1:0];
        pquo = '0;
        pden = den_i;
      end else begin
        prem = rem_q[s-1];
        plow = low_q[s-1];
        pquo = quo_q[s-1];
        pden = den_q[s-1];
      end
      t        = {prem, plow[QW-1]};
      ge       = (t >= {1'b0, pden});
      rem_d[s] = ge ? SW'(t - {1'b0, pden}) : t[SW-1:0];
      low_d[s] = plow << 1;
      quo_d[s] = {pquo[QW-2:0], ge};
      den_d[s] = pden;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        low_q[s] <= low_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

/* sv/chromaticity_nearest_color_classifier_core.sv */
// Color sample classifier.
// Input channel (in_valid_i/in_ready_o) takes red, green, blue and clear
// counts. Output channel (out_valid_o/out_ready_i) returns one result per
// sample: class, three Q1.16 shares of the color sum, the clear count and
// a packed 24-bit hex color.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the white (index
// 0) and black (index 1) clear thresholds; it is always ready and other
// indexes are ignored. Write it only while the block is empty.
// The pipeline has one input stage, 17 divider stages (one quotient bit
// each) and five stages for byte rounding, squared distances and the
// nearest-reference search. Throughput is one sample per cycle. The
// whole pipeline advances as one; when the receiver holds out_ready_i
// low with a result waiting, every stage holds and in_ready_o drops,
// so nothing is lost or repeated. Reset empties the pipeline and loads
// thresholds 60000 and 100.
module chromaticity_nearest_color_classifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ccc_pkg::CNT_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ccc_pkg::CNT_W-1:0]       red_count_i,
  input  logic [ccc_pkg::CNT_W-1:0]       green_count_i,
  input  logic [ccc_pkg::CNT_W-1:0]       blue_count_i,
  input  logic [ccc_pkg::CNT_W-1:0]       clear_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ccc_pkg::CLS_W-1:0]       color_class_o,
  output logic [ccc_pkg::QUO_W-1:0]       red_fraction_o,
  output logic [ccc_pkg::QUO_W-1:0]       green_fraction_o,
  output logic [ccc_pkg::QUO_W-1:0]       blue_fraction_o,
  output logic [ccc_pkg::CNT_W-1:0]       clear_value_o,
  output logic [ccc_pkg::HEX_W-1:0]       packed_hex_o
);

  localparam int F     = ccc_pkg::FRAC_BITS;
  localparam int QW    = ccc_pkg::QUO_W;
  localparam int NW    = ccc_pkg::NUM_W;
  localparam int SW    = ccc_pkg::SUM_W;
  localparam int CW    = ccc_pkg::CNT_W;
  localparam int NU    = ccc_pkg::NUM_USED;
  localparam int NP    = ccc_pkg::NUM_PAIRS;
  localparam int DW    = ccc_pkg::DIST_W;
  localparam int BW    = QW + 9;
  localparam int DEPTH = QW + 6;
  localparam int P1    = QW + 1;

  logic en;
  logic [DEPTH-1:0] v_q;

  logic [CW-1:0] white_thr_q;
  logic [CW-1:0] black_thr_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_thr_q <= ccc_pkg::WHITE_THR_RST;
      black_thr_q <= ccc_pkg::BLACK_THR_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ccc_pkg::CFG_WHITE_THR) white_thr_q <= cfg_data_i;
      if (cfg_index_i == ccc_pkg::CFG_BLACK_THR) black_thr_q <= cfg_data_i;
    end
  end

  // Global advance: the pipeline moves unless a waiting result is stalled
  assign en         = !v_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Input stage: color sum, rounded numerators, threshold decision
  logic [SW-1:0] sum_d;
  logic [NW-1:0] num_q [3];
  logic [SW-1:0] sum_q;
  ccc_pkg::side_t side_d;
  ccc_pkg::side_t side_q [QW+1];

  always_comb begin
    sum_d        = SW'(red_count_i) + SW'(green_count_i) + SW'(blue_count_i);
    side_d.clear = clear_count_i;
    side_d.nz    = (sum_d != '0);
    if (clear_count_i > white_thr_q) side_d.sel = ccc_pkg::SEL_WHITE;
    else if (clear_count_i < black_thr_q) side_d.sel = ccc_pkg::SEL_BLACK;
    else side_d.sel = ccc_pkg::SEL_NEAR;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q     <= sum_d;
      num_q[0]  <= (NW'(red_count_i) << F) + NW'(sum_d >> 1);
      num_q[1]  <= (NW'(green_count_i) << F) + NW'(sum_d >> 1);
      num_q[2]  <= (NW'(blue_count_i) << F) + NW'(sum_d >> 1);
      side_q[0] <= side_d;
      for (int s = 1; s <= QW; s++) side_q[s] <= side_q[s-1];
    end
  end

  // Three share dividers
  logic [QW-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    ccc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[k]),
      .den_i (sum_q),
      .quo_o (quo[k])
    );
  end

  // P1: zero-sum masking, byte rounding, distance components
  logic [QW-1:0] frac_c [3];
  logic [BW-1:0] byte_c [3];
  logic [QW-1:0] frac_q [3];
  logic [7:0]    byte_q [3];
  logic [QW-1:0] diff_q [NU][3];
  ccc_pkg::side_t side1_q, side2_q, side3_q, side4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      frac_c[k] = side_q[QW].nz ? quo[k] : '0;
      byte_c[k] = ((BW'(frac_c[k]) << 8) - BW'(frac_c[k]) + BW'(1 << (F - 1))) >> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_q[QW];
      for (int k = 0; k < 3; k++) begin
        frac_q[k] <= frac_c[k];
        byte_q[k] <= (byte_c[k] > BW'(255)) ? 8'hFF : byte_c[k][7:0];
        for (int i = 0; i < NU; i++) begin
          diff_q[i][k] <= (frac_c[k] >= ccc_pkg::ref_fixed(i, k))
                          ? frac_c[k] - ccc_pkg::ref_fixed(i, k)
                          : ccc_pkg::ref_fixed(i, k) - frac_c[k];
        end
      end
    end
  end

  // P2: squares, P3: distance sums
  logic [ccc_pkg::SQ_W-1:0] sq_q [NU][3];
  logic [DW-1:0] dist_q [NU];
  logic [QW-1:0] frac2_q [3], frac3_q [3], frac4_q [3];
  logic [ccc_pkg::HEX_W-1:0] hex2_q, hex3_q, hex4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      hex2_q  <= {byte_q[0], byte_q[1], byte_q[2]};
      hex3_q  <= hex2_q;
      hex4_q  <= hex3_q;
      for (int k = 0; k < 3; k++) begin
        frac2_q[k] <= frac_q[k];
        frac3_q[k] <= frac2_q[k];
        frac4_q[k] <= frac3_q[k];
      end
      for (int i = 0; i < NU; i++) begin
        for (int k = 0; k < 3; k++) sq_q[i][k] <= diff_q[i][k] * diff_q[i][k];
        dist_q[i] <= DW'(sq_q[i][0]) + DW'(sq_q[i][1]) + DW'(sq_q[i][2]);
      end
    end
  end

  // P4: pairwise minimum, lower index kept on ties
  logic [DW-1:0]               pdist_q [NP];
  logic [ccc_pkg::CLS_W-1:0]   pidx_q  [NP];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < NP; p++) begin
        if ((2 * p + 1 < NU) && (dist_q[(2*p+1) % NU] < dist_q[2*p])) begin
          pdist_q[p] <= dist_q[(2*p+1) % NU];
          pidx_q[p]  <= ccc_pkg::CLS_W'(2 * p + 1);
        end else begin
          pdist_q[p] <= dist_q[2*p];
          pidx_q[p]  <= ccc_pkg::CLS_W'(2 * p);
        end
      end
    end
  end

  // P5: final search over the pairs and result assembly
  logic [DW-1:0]             near_dist;
  logic [ccc_pkg::CLS_W-1:0] best_idx;
  logic [ccc_pkg::CLS_W-1:0] cls_d;

  always_comb begin
    near_dist = pdist_q[0];
    best_idx  = pidx_q[0];
    for (int p = 1; p < NP; p++) begin
      if (pdist_q[p] < near_dist) begin
        near_dist = pdist_q[p];
        best_idx  = pidx_q[p];
      end
    end
    case (side4_q.sel)
      ccc_pkg::SEL_WHITE: cls_d = ccc_pkg::CLS_WHITE;
      ccc_pkg::SEL_BLACK: cls_d = ccc_pkg::CLS_BLACK;
      default:            cls_d = best_idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      color_class_o    <= cls_d;
      red_fraction_o   <= frac4_q[0];
      green_fraction_o <= frac4_q[1];
      blue_fraction_o  <= frac4_q[2];
      clear_value_o    <= side4_q.nz ? side4_q.clear : '0;
      packed_hex_o     <= hex4_q;
    end
  end

  assign out_valid_o = v_q[DEPTH-1];

`ifndef SYNTH
  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> color_class_o <= ccc_pkg::CLS_BLACK)
    else $error("class code out of range");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_fraction_o <= QW'(1 << F)) && (green_fraction_o <= QW'(1 << F))
                    && (blue_fraction_o <= QW'(1 << F)))
    else $error("fraction above one");

  a_zero_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && red_fraction_o == '0 && green_fraction_o == '0
     && blue_fraction_o == '0) |-> packed_hex_o == '0)
    else $error("hex color nonzero for zero fractions");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[P1] && !en) |=> v_q[P1])
    else $error("pipeline stage lost an item while stalled");
`endif

endmodule

/* test/tb_chromaticity_nearest_color_classifier_core.sv */
module tb_chromaticity_nearest_color_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 23;
  localparam int WDOG_MAX  = 20000;
  localparam int RAND_ITEMS = 1250;

  typedef struct packed {
    logic [ccc_pkg::CLS_W-1:0] cls;
    logic [ccc_pkg::QUO_W-1:0] r_frac;
    logic [ccc_pkg::QUO_W-1:0] g_frac;
    logic [ccc_pkg::QUO_W-1:0] b_frac;
    logic [ccc_pkg::CNT_W-1:0] clear;
    logic [ccc_pkg::HEX_W-1:0] hex;
  } color_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [ccc_pkg::CNT_W-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [ccc_pkg::CNT_W-1:0]     red_count_i, green_count_i, blue_count_i, clear_count_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [ccc_pkg::CLS_W-1:0]     color_class_o;
  logic [ccc_pkg::QUO_W-1:0]     red_fraction_o, green_fraction_o, blue_fraction_o;
  logic [ccc_pkg::CNT_W-1:0]     clear_value_o;
  logic [ccc_pkg::HEX_W-1:0]     packed_hex_o;

  chromaticity_nearest_color_classifier_core u_dut (.*);

  // Thresholds as the testbench believes them to be
  logic [ccc_pkg::CNT_W-1:0] white_thr_q;
  logic [ccc_pkg::CNT_W-1:0] black_thr_q;

  color_result_t expected_colors[$];
  int  error_cnt;
  int  sample_cnt;
  int  result_cnt;
  int  idle_cnt;
  int  send_idle_pct;
  int  recv_stall_pct;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded share of the color sum in Q1.16, zero for a zero sum
  function automatic logic [ccc_pkg::QUO_W-1:0] color_share(
      logic [ccc_pkg::CNT_W-1:0] cnt, logic [ccc_pkg::SUM_W-1:0] sum);
    longint unsigned num;
    if (sum == 0) return '0;
    num = (longint'(cnt) << ccc_pkg::FRAC_BITS) + (sum >> 1);
    return ccc_pkg::QUO_W'(num / sum);
  endfunction

  function automatic logic [7:0] share_byte(logic [ccc_pkg::QUO_W-1:0] frac);
    longint unsigned v;
    v = (longint'(frac) * 255 + (64'd1 << (ccc_pkg::FRAC_BITS - 1))) >> ccc_pkg::FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Reference table rebuilt locally in thousandths
  function automatic int ref_comp_milli(int idx, int comp);
    int tbl[10][3];
    tbl = '{'{479, 271, 249}, '{506, 258, 232}, '{334, 333, 331},
            '{348, 336, 315}, '{343, 336, 320}, '{343, 374, 263},
            '{415, 360, 225}, '{480, 286, 235}, '{359, 354, 294},
            '{443, 312, 244}};
    return tbl[idx][comp];
  endfunction

  function automatic color_result_t classify_sample(logic [ccc_pkg::CNT_W-1:0] r,
      logic [ccc_pkg::CNT_W-1:0] g, logic [ccc_pkg::CNT_W-1:0] b,
      logic [ccc_pkg::CNT_W-1:0] c);
    color_result_t             res;
    logic [ccc_pkg::SUM_W-1:0] sum;
    longint unsigned           frac[3];
    longint unsigned           min_sq, sq_sum, refv, d;
    int                        best_idx;
    sum = ccc_pkg::SUM_W'(r) + ccc_pkg::SUM_W'(g) + ccc_pkg::SUM_W'(b);
    res.r_frac = color_share(r, sum);
    res.g_frac = color_share(g, sum);
    res.b_frac = color_share(b, sum);
    res.clear  = (sum != 0) ? c : '0;
    res.hex    = {share_byte(res.r_frac), share_byte(res.g_frac), share_byte(res.b_frac)};
    frac[0] = res.r_frac;
    frac[1] = res.g_frac;
    frac[2] = res.b_frac;
    best_idx = 0;
    min_sq   = 0;
    for (int i = 0; i < ccc_pkg::NUM_USED; i++) begin
      sq_sum = 0;
      for (int k = 0; k < 3; k++) begin
        refv = ((longint'(ref_comp_milli(i, k)) << ccc_pkg::FRAC_BITS) + 500) / 1000;
        d = (frac[k] >= refv) ? frac[k] - refv : refv - frac[k];
        sq_sum += d * d;
      end
      if (i == 0 || sq_sum < min_sq) begin
        min_sq   = sq_sum;
        best_idx = i;
      end
    end
    if (c > white_thr_q)      res.cls = ccc_pkg::CLS_WHITE;
    else if (c < black_thr_q) res.cls = ccc_pkg::CLS_BLACK;
    else                      res.cls = ccc_pkg::CLS_W'(best_idx);
    return res;
  endfunction

  // Result checker and watchdog
  always @(posedge clk_i) begin
    color_result_t act, exp_res;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("chromaticity_nearest_color_classifier_core verification failed");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        act = '{color_class_o, red_fraction_o, green_fraction_o, blue_fraction_o,
                clear_value_o, packed_hex_o};
        result_cnt <= result_cnt + 1;
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result %h", $time, act);
          error_cnt <= error_cnt + 1;
        end else begin
          exp_res = expected_colors.pop_front();
          if (act !== exp_res) begin
            $display("%0t: mismatch exp cls=%0d r=%h g=%h b=%h c=%h hex=%h", $time,
                     exp_res.cls, exp_res.r_frac, exp_res.g_frac, exp_res.b_frac,
                     exp_res.clear, exp_res.hex);
            $display("%0t:          act cls=%0d r=%h g=%h b=%h c=%h hex=%h", $time,
                     act.cls, act.r_frac, act.g_frac, act.b_frac, act.clear, act.hex);
            error_cnt <= error_cnt + 1;
          end
        end
      end
    end
  end

  // Receiver stalls, redrawn at each falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high into the next sample unless the sender idles
  task automatic send_sample(logic [ccc_pkg::CNT_W-1:0] r, logic [ccc_pkg::CNT_W-1:0] g,
                             logic [ccc_pkg::CNT_W-1:0] b, logic [ccc_pkg::CNT_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_count_i   <= r;
    green_count_i <= g;
    blue_count_i  <= b;
    clear_count_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_colors.push_back(classify_sample(r, g, b, c));
    sample_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [ccc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [ccc_pkg::CNT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == ccc_pkg::CFG_WHITE_THR)      white_thr_q = val;
    else if (idx == ccc_pkg::CFG_BLACK_THR) black_thr_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Field extremes, zero sum, threshold edges, each reference point
  task automatic test_directed();
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 0, 500);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 0, 0, 1000);
    send_sample(0, 16'hFFFF, 0, 1000);
    send_sample(0, 0, 16'hFFFF, 1000);
    send_sample(1, 1, 1, 60000);
    send_sample(1, 1, 1, 60001);
    send_sample(5, 7, 9, 100);
    send_sample(5, 7, 9, 99);
    for (int i = 0; i < ccc_pkg::NUM_USED; i++)
      send_sample(16'(ref_comp_milli(i, 0) * 50), 16'(ref_comp_milli(i, 1) * 50),
                  16'(ref_comp_milli(i, 2) * 50), 30000);
    send_sample(16'hAAAA, 16'h5555, 16'h0001, 16'h8000);
    drain_pipeline();
  endtask

  // Random samples, mostly mid-range clear so the nearest search runs
  task automatic test_random(int n_items);
    logic [ccc_pkg::CNT_W-1:0] r, g, b, c;
    int                        base;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(3) == 0) begin
        r = ccc_pkg::CNT_W'($urandom);
        g = ccc_pkg::CNT_W'($urandom);
        b = ccc_pkg::CNT_W'($urandom);
        c = ccc_pkg::CNT_W'($urandom);
      end else begin
        base = $urandom_range(1, 60);
        r = 16'(ref_comp_milli(i % ccc_pkg::NUM_USED, 0) * base + $urandom_range(200));
        g = 16'(ref_comp_milli(i % ccc_pkg::NUM_USED, 1) * base + $urandom_range(200));
        b = 16'(ref_comp_milli(i % ccc_pkg::NUM_USED, 2) * base + $urandom_range(200));
        c = ccc_pkg::CNT_W'($urandom_range(black_thr_q, white_thr_q));
      end
      send_sample(r, g, b, c);
    end
    drain_pipeline();
  endtask

  task automatic test_thresholds();
    write_threshold(ccc_pkg::CFG_WHITE_THR, 16'hFFFF);
    write_threshold(ccc_pkg::CFG_BLACK_THR, 16'h0000);
    test_random(150);
    write_threshold(ccc_pkg::CFG_WHITE_THR, 16'h0000);
    write_threshold(ccc_pkg::CFG_BLACK_THR, 16'hFFFF);
    send_sample(3, 4, 5, 0);
    send_sample(3, 4, 5, 16'hFFFF);
    test_random(50);
    write_threshold(ccc_pkg::CFG_WHITE_THR, 16'd40000);
    write_threshold(ccc_pkg::CFG_BLACK_THR, 16'd2000);
    write_threshold(2'd3, 16'd1234);
    test_random(150);
  endtask

  initial begin
    error_cnt = 0; sample_cnt = 0; result_cnt = 0; idle_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    white_thr_q = ccc_pkg::WHITE_THR_RST;
    black_thr_q = ccc_pkg::BLACK_THR_RST;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b1;
    red_count_i = '0; green_count_i = '0; blue_count_i = '0; clear_count_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(400);
    send_idle_pct = 70; recv_stall_pct = 0;
    test_random(200);
    send_idle_pct = 0; recv_stall_pct = 70;
    test_random(200);
    send_idle_pct = 34; recv_stall_pct = 34;
    test_random(50);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_thresholds();

    $display("Covered %0d samples, %0d results, over four idle/stall phases", sample_cnt,
             result_cnt);
    $display("and white/black threshold settings including both extremes.");
    if (error_cnt == 0 && expected_colors.size() == 0)
      $display("chromaticity_nearest_color_classifier_core verification clean");
    else
      $display("chromaticity_nearest_color_classifier_core verification failed");
    $finish;
  end

endmodule

/* chromaticity_nearest_color_classifier_core.f */
sv/ccc_pkg.sv
sv/ccc_div.sv
sv/chromaticity_nearest_color_classifier_core.sv
test/tb_chromaticity_nearest_color_classifier_core.sv
